### design/klc_pkg.sv
// ---------------------------------------------------------------------------
// klc_pkg: shared types and constants for the K-of-N confirm/latch block
// Holds register indexes, operation and verdict codes and reset values.
// ---------------------------------------------------------------------------
package klc_pkg;

  localparam int MAX_WINDOW_DEF = 64;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH     = 2'd0,
    REG_CONFIRM_THRESHOLD = 2'd1,
    REG_LATCH_ENABLE      = 2'd2,
    REG_TIMEOUT_MS        = 2'd3
  } cfg_reg_t;

  // input operation codes
  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  // frame verdict codes; any other code counts as unusable
  localparam logic [1:0] VERDICT_GREEN     = 2'd0;
  localparam logic [1:0] VERDICT_NOT_GREEN = 2'd1;
  localparam logic [1:0] VERDICT_UNUSABLE  = 2'd2;

  // register reset values
  localparam logic [6:0]  WINDOW_LENGTH_RST     = 7'd8;
  localparam logic [6:0]  CONFIRM_THRESHOLD_RST = 7'd4;
  localparam logic        LATCH_ENABLE_RST      = 1'b1;
  localparam logic [15:0] TIMEOUT_MS_RST        = 16'd500;

endpackage

### design/klc_window_ram.sv
// ---------------------------------------------------------------------------
// klc_window_ram: sample ring storage
// One write port, one registered read port; a write to the address being
// read in the same cycle is forwarded to the read data.
// ---------------------------------------------------------------------------
module klc_window_ram #(
  parameter int DEPTH = klc_pkg::MAX_WINDOW_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-during-write returns the new sample
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/k_of_n_confirm_latch_timeout_top.sv
// ---------------------------------------------------------------------------
// k_of_n_confirm_latch_timeout_top: K-of-N green confirmation with latch
// and camera timeout
// Sliding window of frame verdicts, grant on K greens, optional permanent
// latch, and a tick-driven timeout that empties the window.
// ---------------------------------------------------------------------------
// Usage: every transfer on the input channel (a frame verdict or a timer
// tick) yields exactly one result transfer showing the state after that
// item. The block sustains one item per clock while the result register is
// free or being taken. Each item passes from the input register to the
// result register. The rate rests on the combinational update of the
// window counters and flags, with the oldest window sample prefetched each
// cycle from the ring RAM so the pop needs no extra read. A full result
// register that is not taken holds one item in the input register before
// input stalls. Configuration writes are always accepted and must only be
// issued while the block is idle. The ring RAM needs no clearing pass:
// only written samples are ever used.
// ---------------------------------------------------------------------------
module k_of_n_confirm_latch_timeout_top #(
  parameter int MAX_WINDOW = klc_pkg::MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // item input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [1:0]  verdict,
  input  logic [31:0] now_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        permission,
  output logic        is_latched,
  output logic        camera_ok,
  output logic [6:0]  green_total,
  output logic [6:0]  window_fill,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  import klc_pkg::*;

  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW   = $clog2(MAX_WINDOW + 1);   // counts 0..MAX_WINDOW
  localparam int CMPW = (CW > 7) ? CW : 7;        // common compare width
  localparam int SW   = AW + 2;                   // ring index sum width

  localparam logic [CMPW-1:0] MAXW_C  = CMPW'(MAX_WINDOW);
  localparam logic [SW-1:0]   MAXW_S  = SW'(MAX_WINDOW);
  localparam logic [AW-1:0]   LAST_IX = AW'(MAX_WINDOW - 1);

  // configuration registers
  logic [6:0]  window_length;
  logic [6:0]  confirm_threshold;
  logic        latch_enable;
  logic [15:0] timeout_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length     <= WINDOW_LENGTH_RST;
      confirm_threshold <= CONFIRM_THRESHOLD_RST;
      latch_enable      <= LATCH_ENABLE_RST;
      timeout_ms        <= TIMEOUT_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LENGTH:     window_length     <= cfg_data[6:0];
        REG_CONFIRM_THRESHOLD: confirm_threshold <= cfg_data[6:0];
        REG_LATCH_ENABLE:      latch_enable      <= cfg_data[0];
        REG_TIMEOUT_MS:        timeout_ms        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        s1_valid;
  logic        s1_op;
  logic [1:0]  s1_verdict;
  logic [31:0] s1_now;
  logic        fire;

  // process the held item when the result register is free or draining
  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op      <= op;
      s1_verdict <= verdict;
      s1_now     <= now_ms;
    end
  end

  // block state
  logic [AW-1:0] head;
  logic [CW-1:0] fill_count;
  logic [CW-1:0] green_count;
  logic          permitted_flag;
  logic          latched_flag;
  logic          camera_active_flag;
  logic          frame_seen_flag;
  logic [31:0]   last_frame_time;

  logic [AW-1:0] head_next;
  logic [CW-1:0] fill_count_next;
  logic [CW-1:0] green_count_next;
  logic          permitted_flag_next;
  logic          latched_flag_next;
  logic          camera_active_flag_next;
  logic          frame_seen_flag_next;
  logic [31:0]   last_frame_time_next;

  // push datapath
  logic            head_bit;      // prefetched oldest sample
  logic [CW-1:0]   win_len;
  logic [CMPW-1:0] wl_ext;
  logic            do_pop;
  logic [AW-1:0]   head_mid;
  logic [CW-1:0]   fill_mid;
  logic [CW-1:0]   green_mid;
  logic [SW-1:0]   tail_sum;
  logic [AW-1:0]   tail;
  logic            usable;
  logic            push_green;
  logic [CW-1:0]   fill_push;
  logic [CW-1:0]   green_push;
  logic            grant;
  logic            push_en;
  logic [31:0]     gap;

  // effective window length, clamped to 1..MAX_WINDOW
  always_comb begin
    wl_ext = CMPW'(window_length);
    if (wl_ext == '0) begin
      win_len = CW'(1);
    end else if (wl_ext > MAXW_C) begin
      win_len = CW'(MAX_WINDOW);
    end else begin
      win_len = CW'(window_length);
    end
  end

  assign usable     = (s1_verdict == VERDICT_GREEN) || (s1_verdict == VERDICT_NOT_GREEN);
  assign push_green = (s1_verdict == VERDICT_GREEN);

  // drop the oldest sample once the window is full
  always_comb begin
    do_pop    = (CMPW'(fill_count) >= CMPW'(win_len));
    head_mid  = head;
    fill_mid  = fill_count;
    green_mid = green_count;
    if (do_pop) begin
      head_mid = (head == LAST_IX) ? '0 : AW'(head + 1'b1);
      fill_mid = fill_count - 1'b1;
      if (head_bit && (green_count != '0)) begin
        green_mid = green_count - 1'b1;
      end
    end
    tail_sum = SW'(head_mid) + SW'(fill_mid);
    if (tail_sum >= MAXW_S) begin
      tail_sum = tail_sum - MAXW_S;
    end
    tail       = AW'(tail_sum);
    fill_push  = fill_mid + 1'b1;
    green_push = green_mid + CW'(push_green);
    grant      = (CMPW'(green_push) >= CMPW'(confirm_threshold));
  end

  assign gap = s1_now - last_frame_time;

  always_comb begin
    head_next               = head;
    fill_count_next         = fill_count;
    green_count_next        = green_count;
    permitted_flag_next     = permitted_flag;
    latched_flag_next       = latched_flag;
    camera_active_flag_next = camera_active_flag;
    frame_seen_flag_next    = frame_seen_flag;
    last_frame_time_next    = last_frame_time;
    push_en                 = 1'b0;
    if (fire) begin
      case (op_t'(s1_op))
        OP_FRAME: begin
          if (usable) begin
            frame_seen_flag_next    = 1'b1;
            last_frame_time_next    = s1_now;
            camera_active_flag_next = 1'b1;
          end
          // once latched, frames only refresh camera status
          if (!latched_flag) begin
            push_en          = 1'b1;
            head_next        = head_mid;
            fill_count_next  = fill_push;
            green_count_next = green_push;
            if (grant) begin
              permitted_flag_next = 1'b1;
              if (latch_enable) begin
                latched_flag_next = 1'b1;
              end
            end else begin
              permitted_flag_next = 1'b0;
            end
          end
        end
        OP_TICK: begin
          if (!latched_flag) begin
            if (!frame_seen_flag) begin
              camera_active_flag_next = 1'b0;
            end else if (s1_now < last_frame_time) begin
              // clock went backward: resync only
              last_frame_time_next = s1_now;
            end else if (gap > 32'(timeout_ms)) begin
              camera_active_flag_next = 1'b0;
              head_next               = '0;
              fill_count_next         = '0;
              green_count_next        = '0;
              permitted_flag_next     = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head               <= '0;
      fill_count         <= '0;
      green_count        <= '0;
      permitted_flag     <= 1'b0;
      latched_flag       <= 1'b0;
      camera_active_flag <= 1'b0;
      frame_seen_flag    <= 1'b0;
      last_frame_time    <= '0;
    end else begin
      head               <= head_next;
      fill_count         <= fill_count_next;
      green_count        <= green_count_next;
      permitted_flag     <= permitted_flag_next;
      latched_flag       <= latched_flag_next;
      camera_active_flag <= camera_active_flag_next;
      frame_seen_flag    <= frame_seen_flag_next;
      last_frame_time    <= last_frame_time_next;
    end
  end

  // ring storage; read address follows the next head so the oldest
  // sample is ready when the next item arrives
  klc_window_ram #(
    .DEPTH (MAX_WINDOW),
    .AW    (AW)
  ) u_window (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_addr (tail),
    .wr_data (push_green),
    .rd_addr (head_next),
    .rd_data (head_bit)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      permission  <= latched_flag_next || permitted_flag_next;
      is_latched  <= latched_flag_next;
      camera_ok   <= camera_active_flag_next;
      green_total <= 7'(green_count_next);
      window_fill <= 7'(fill_count_next);
    end
  end

`ifndef NO_ASSERTIONS
  // green samples are a subset of the held samples
  a_green_le_fill: assert property (@(posedge clk) disable iff (rst)
    green_count <= fill_count)
    else $error("green count exceeds window fill");

  // the window never holds more than its storage
  a_fill_le_max: assert property (@(posedge clk) disable iff (rst)
    CMPW'(fill_count) <= MAXW_C)
    else $error("window fill exceeds storage depth");

  // a latch is permanent until reset
  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    latched_flag |=> latched_flag)
    else $error("latched grant was released");

  // a latched block always reports permission
  a_latched_permits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_latched) |-> permission)
    else $error("latched result without permission");
`endif

endmodule
